### sv/tks_pkg.sv
// Shared types, widths and the ranking function of the top-k score selector.
package tks_pkg;

    localparam int ID_W    = 64;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 6;
    localparam int CFG_W   = 7;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } pair_t;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic insert_en;
        logic shift_en;
    } cell_ctrl_t;

    typedef enum logic {
        S_COLLECT,
        S_DRAIN
    } sel_state_t;

    // True when pair a ranks strictly ahead of pair b: higher score first,
    // and on equal scores the smaller id first.
    function automatic logic ranks_ahead(pair_t a, pair_t b);
        logic res;
        if (a.score != b.score)
        begin
            res = (a.score > b.score);
        end
        else
        begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage

### sv/tks_cell.sv
// One cell of the sorted row: holds one pair, inserts or shifts with its neighbors.
module tks_cell (
    input  logic               clk,
    input  tks_pkg::cell_ctrl_t ctrl,
    input  tks_pkg::pair_t     new_pair,
    input  logic               occupied,
    input  logic               left_ahead,
    input  tks_pkg::pair_t     left_data,
    input  tks_pkg::pair_t     right_data,
    output logic               ahead,
    output tks_pkg::pair_t     data
);

    tks_pkg::pair_t data_reg;
    tks_pkg::pair_t data_next;

    // An empty cell loses to any incoming pair, so the row stays packed.
    assign ahead = !occupied || tks_pkg::ranks_ahead(new_pair, data_reg);
    assign data  = data_reg;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shift_en)
        begin
            data_next = right_data;
        end
        else if (ctrl.insert_en && ahead)
        begin
            // If the new pair also beats the cell to the left, this cell takes
            // the left neighbor's pair; otherwise the new pair lands here.
            data_next = left_ahead ? left_data : new_pair;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### sv/top_k_score_selector.sv
// Top level of the top-k score selector: a row of insertion cells plus the drain controller.
//
// Pairs enter one per clock into a sorted row of MAX_KEEP cells; each cell
// compares the incoming pair with its own and either keeps, takes the new pair
// or takes its left neighbor's, so a new pair is placed on every beat. After
// the beat that carries final_pair, the block stops accepting input and
// shifts the row toward cell 0, delivering one result beat per cycle in which
// the output register is free, best first; the set has n result beats, with
// n the smaller of the clamped keep_count and the number of pairs held. The
// row is empty again after the last result beat is loaded.
module top_k_score_selector #(
    parameter int MAX_KEEP = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tks_pkg::ID_W-1:0]    item_id,
    input  logic [tks_pkg::SCORE_W-1:0] item_score,
    input  logic                        final_pair,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tks_pkg::ID_W-1:0]    chosen_id,
    output logic [tks_pkg::RANK_W-1:0]  rank_pos,
    output logic                        run_end,
    input  logic                        cfg_we,
    input  logic [tks_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int FILL_W = $clog2(MAX_KEEP + 1);

    tks_pkg::sel_state_t state_reg, state_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [tks_pkg::RANK_W-1:0] rank_cnt_reg, rank_cnt_next;
    logic [tks_pkg::RANK_W-1:0] last_rank_reg, last_rank_next;
    logic [tks_pkg::CFG_W-1:0]  keep_count_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [tks_pkg::ID_W-1:0]   chosen_id_reg;
    logic [tks_pkg::RANK_W-1:0] rank_pos_reg;
    logic                       run_end_reg;

    tks_pkg::cell_ctrl_t ctrl;
    tks_pkg::pair_t      new_pair;
    tks_pkg::pair_t      cell_data [MAX_KEEP];
    logic [MAX_KEEP-1:0] cell_ahead;
    logic [MAX_KEEP-1:0] cell_occ;

    logic                      accept;
    logic                      drain_load;
    logic                      last_beat;
    logic                      not_full;
    logic [tks_pkg::CFG_W-1:0] limit;
    logic [tks_pkg::CFG_W-1:0] fill_after;
    logic [tks_pkg::CFG_W-1:0] emit_n;

    assign new_pair.id    = item_id;
    assign new_pair.score = item_score;

    assign accept     = in_valid && in_ready;
    assign drain_load = (state_reg == tks_pkg::S_DRAIN) && (!out_valid_reg || out_ready);
    assign last_beat  = drain_load && (rank_cnt_reg == last_rank_reg);
    assign not_full   = (fill_reg < FILL_W'(MAX_KEEP));

    // Output count for this set: clamped keep_count against pairs held after this beat.
    always_comb
    begin
        priority if (keep_count_reg == '0)
        begin
            limit = tks_pkg::CFG_W'(1);
        end
        else if (keep_count_reg > tks_pkg::CFG_W'(MAX_KEEP))
        begin
            limit = tks_pkg::CFG_W'(MAX_KEEP);
        end
        else
        begin
            limit = keep_count_reg;
        end
        fill_after = tks_pkg::CFG_W'(fill_reg) + tks_pkg::CFG_W'(not_full);
        emit_n     = (fill_after < limit) ? fill_after : limit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            tks_pkg::pair_t left_d;
            tks_pkg::pair_t right_d;
            logic           left_a;

            assign cell_occ[gi] = (FILL_W'(gi) < fill_reg);

            if (gi == 0)
            begin : g_head
                assign left_a = 1'b0;
                assign left_d = new_pair;
            end
            else
            begin : g_body
                assign left_a = cell_ahead[gi-1];
                assign left_d = cell_data[gi-1];
            end

            if (gi == MAX_KEEP - 1)
            begin : g_tail
                assign right_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            tks_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_pair   (new_pair),
                .occupied   (cell_occ[gi]),
                .left_ahead (left_a),
                .left_data  (left_d),
                .right_data (right_d),
                .ahead      (cell_ahead[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tks_pkg::S_COLLECT:
            begin
                if (accept && final_pair)
                begin
                    state_next = tks_pkg::S_DRAIN;
                end
            end
            tks_pkg::S_DRAIN:
            begin
                if (last_beat)
                begin
                    state_next = tks_pkg::S_COLLECT;
                end
            end
            default:
            begin
                state_next = tks_pkg::S_COLLECT;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        ctrl.insert_en = 1'b0;
        ctrl.shift_en  = 1'b0;
        unique case (state_reg)
            tks_pkg::S_COLLECT:
            begin
                in_ready       = 1'b1;
                ctrl.insert_en = in_valid;
            end
            tks_pkg::S_DRAIN:
            begin
                ctrl.shift_en = drain_load;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        rank_cnt_next  = rank_cnt_reg;
        last_rank_next = last_rank_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            fill_next = fill_reg + FILL_W'(not_full);
            if (final_pair)
            begin
                rank_cnt_next  = '0;
                last_rank_next = tks_pkg::RANK_W'(emit_n - tks_pkg::CFG_W'(1));
            end
        end

        if (drain_load)
        begin
            rank_cnt_next = rank_cnt_reg + tks_pkg::RANK_W'(1);
            if (last_beat)
            begin
                fill_next = '0;
            end
        end

        priority if (drain_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tks_pkg::S_COLLECT;
            fill_reg       <= '0;
            rank_cnt_reg   <= '0;
            last_rank_reg  <= '0;
            out_valid_reg  <= 1'b0;
            keep_count_reg <= tks_pkg::CFG_W'(64);
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rank_cnt_reg  <= rank_cnt_next;
            last_rank_reg <= last_rank_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                keep_count_reg <= cfg_wdata;
            end
        end
    end

    // The best pair sits in cell 0 while the row drains.
    always_ff @(posedge clk)
    begin
        if (drain_load)
        begin
            chosen_id_reg <= cell_data[0].id;
            rank_pos_reg  <= rank_cnt_reg;
            run_end_reg   <= (rank_cnt_reg == last_rank_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign chosen_id = chosen_id_reg;
    assign rank_pos  = rank_pos_reg;
    assign run_end   = run_end_reg;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the top-k score selector: streamed pairs, ranked id beats.

typedef struct {
    logic [tks_pkg::ID_W-1:0]   id;
    logic [tks_pkg::RANK_W-1:0] rank;
    logic                       last;
} ranked_id_t;

class topk_scoreboard;
    localparam int ROW_DEPTH = 64;

    logic [tks_pkg::ID_W-1:0]    row_id[$];
    logic [tks_pkg::SCORE_W-1:0] row_score[$];
    logic [tks_pkg::CFG_W-1:0]   keep_reg;
    ranked_id_t                  ranked_ids_due[$];
    int                          errors;

    function new();
        keep_reg = 7'd64;
        errors   = 0;
    endfunction

    // Higher score wins; equal scores go to the smaller id.
    function bit outranks(logic [tks_pkg::ID_W-1:0] ia, logic [tks_pkg::SCORE_W-1:0] sa,
                          logic [tks_pkg::ID_W-1:0] ib, logic [tks_pkg::SCORE_W-1:0] sb);
        if (sa != sb)
        begin
            return sa > sb;
        end
        return ia < ib;
    endfunction

    function void write_keep(logic [tks_pkg::CFG_W-1:0] value);
        keep_reg = value;
    endfunction

    function int pending();
        return ranked_ids_due.size();
    endfunction

    // Takes one accepted input beat into the sorted row and, on the closing
    // pair of a set, queues the ids that the block must emit.
    function void note_pair(logic [tks_pkg::ID_W-1:0] id, logic [tks_pkg::SCORE_W-1:0] score,
                            logic fin);
        int         pos;
        int         i;
        int         limit;
        ranked_id_t entry;
        pos = row_id.size();
        for (i = 0; i < row_id.size(); i++)
        begin
            if (outranks(id, score, row_id[i], row_score[i]))
            begin
                pos = i;
                break;
            end
        end
        if (pos < ROW_DEPTH)
        begin
            row_id.insert(pos, id);
            row_score.insert(pos, score);
            if (row_id.size() > ROW_DEPTH)
            begin
                void'(row_id.pop_back());
                void'(row_score.pop_back());
            end
        end
        if (fin)
        begin
            if (keep_reg == 0)
            begin
                limit = 1;
            end
            else if (keep_reg > ROW_DEPTH)
            begin
                limit = ROW_DEPTH;
            end
            else
            begin
                limit = keep_reg;
            end
            if (limit > row_id.size())
            begin
                limit = row_id.size();
            end
            for (i = 0; i < limit; i++)
            begin
                entry.id   = row_id[i];
                entry.rank = i[tks_pkg::RANK_W-1:0];
                entry.last = (i == limit - 1);
                ranked_ids_due.insert(ranked_ids_due.size(), entry);
            end
            row_id.delete();
            row_score.delete();
        end
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("%s", msg);
    endtask

    task check_result(logic [tks_pkg::ID_W-1:0] id, logic [tks_pkg::RANK_W-1:0] rank,
                      logic last);
        ranked_id_t want;
        if (ranked_ids_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result beat: id %h rank %0d run_end %0b",
                                      id, rank, last));
        end
        else
        begin
            want = ranked_ids_due.pop_front();
            if (id !== want.id)
            begin
                report_mismatch($sformatf("chosen_id mismatch at rank %0d: got %h want %h",
                                          want.rank, id, want.id));
            end
            if (rank !== want.rank)
            begin
                report_mismatch($sformatf("rank_pos mismatch: got %0d want %0d",
                                          rank, want.rank));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("run_end mismatch at rank %0d: got %b want %b",
                                          want.rank, last, want.last));
            end
        end
    endtask
endclass

module tb_top;
    localparam int CLK_PERIOD     = 20;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 200000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [tks_pkg::ID_W-1:0]    item_id;
    logic [tks_pkg::SCORE_W-1:0] item_score;
    logic                        final_pair;
    logic                        out_valid;
    logic                        out_ready;
    logic [tks_pkg::ID_W-1:0]    chosen_id;
    logic [tks_pkg::RANK_W-1:0]  rank_pos;
    logic                        run_end;
    logic                        cfg_we;
    logic [tks_pkg::CFG_W-1:0]   cfg_wdata;

    int             sender_idle_pct;
    int             recv_stall_pct;
    topk_scoreboard sb;

    top_k_score_selector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_id    (item_id),
        .item_score (item_score),
        .final_pair (final_pair),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .chosen_id  (chosen_id),
        .rank_pos   (rank_pos),
        .run_end    (run_end),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_pair(item_id, item_score, final_pair);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(chosen_id, rank_pos, run_end);
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pair(input logic [tks_pkg::ID_W-1:0] id,
                             input logic [tks_pkg::SCORE_W-1:0] score, input logic fin);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        item_id    <= id;
        item_score <= score;
        final_pair <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_keep_count(input logic [tks_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        sb.write_keep(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [tks_pkg::ID_W-1:0] rand_id();
        // Small ids make score ties resolve by id and produce repeated ids.
        if ($urandom_range(3) == 0)
        begin
            return 64'($urandom_range(0, 15));
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [tks_pkg::SCORE_W-1:0] rand_score();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [tks_pkg::CFG_W-1:0] pick_keep();
        case ($urandom_range(5))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'($urandom_range(1, 4));
            3:       return 7'd64;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_set(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_pair(rand_id(), rand_score(), i == count - 1);
        end
    endtask

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int phase;
        int phase_items;
        int budget;
        int set_len;
        sb              = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        item_id         = '0;
        item_score      = '0;
        final_pair      = 1'b0;
        out_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset value of keep_count, field extremes, a score tie and a repeated id.
        send_pair(64'd0, 32'd0, 1'b0);
        send_pair('1, '1, 1'b0);
        send_pair(64'd5, 32'd100, 1'b0);
        send_pair(64'd3, 32'd100, 1'b0);
        send_pair(64'd5, 32'd7, 1'b0);
        send_pair(64'd1, 32'h8000_0000, 1'b1);
        // A set made of its closing pair alone.
        send_pair(64'h8000_0000_0000_0000, 32'd0, 1'b1);

        // A zero count still returns the best id.
        wait_drained();
        write_keep_count(7'd0);
        send_pair(64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 1'b0);
        send_pair(64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 1'b0);
        send_pair(64'd9, 32'hAAAA_5555, 1'b1);

        // Counts above the row depth saturate.
        wait_drained();
        write_keep_count(7'd127);
        send_pair(64'd20, 32'd3, 1'b0);
        send_pair(64'd21, 32'd3, 1'b0);
        send_pair(64'd22, 32'd4, 1'b1);

        // The count in force at the closing pair decides, even if changed mid-set.
        wait_drained();
        write_keep_count(7'd2);
        send_pair(64'd40, 32'd10, 1'b0);
        send_pair(64'd41, 32'd30, 1'b0);
        send_pair(64'd42, 32'd20, 1'b0);
        send_pair(64'd43, 32'd40, 1'b0);
        wait_drained();
        write_keep_count(7'd3);
        send_pair(64'd44, 32'd25, 1'b1);

        wait_drained();
        write_keep_count(7'd65);
        send_pair(64'd50, 32'd1, 1'b0);
        send_pair(64'd51, 32'd2, 1'b1);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            phase_items = 0;
            budget      = 5;
            if (phase == 0)
            begin
                // Overfill the row so that weak pairs drop and strong ones push out the worst.
                write_keep_count(7'd64);
                send_set(66);
                phase_items = 66;
                budget      = 67;
            end
            while (phase_items < budget)
            begin
                if ($urandom_range(2) == 0)
                begin
                    wait_drained();
                    write_keep_count(pick_keep());
                end
                set_len = $urandom_range(1, 8);
                send_set(set_len);
                phase_items += set_len;
            end
            wait_drained();
        end

        if (sb.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### filelist.f
sv/tks_pkg.sv
sv/tks_cell.sv
sv/top_k_score_selector.sv
sim/tb_top.sv
